// ===== hdl/soc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soc_pkg: shared types for the segment occlusion test
// Sign flags of an exact cross-product difference.
// ----------------------------------------------------------------------------
package soc_pkg;

	typedef struct packed {
		logic neg;
		logic pos;
	} sgn_t;

endpackage
`default_nettype wire

// ===== hdl/soc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soc_if: valid/ready channels of the segment occlusion test
// Segment pair channel and result flag channel.
// ----------------------------------------------------------------------------
interface soc_in_if #(
	parameter int CW = 24
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] p_start_x;
	logic signed [CW-1:0] p_start_y;
	logic signed [CW-1:0] p_end_x;
	logic signed [CW-1:0] p_end_y;
	logic signed [CW-1:0] q_start_x;
	logic signed [CW-1:0] q_start_y;
	logic signed [CW-1:0] q_end_x;
	logic signed [CW-1:0] q_end_y;

	modport source (
		output valid, p_start_x, p_start_y, p_end_x, p_end_y,
		output q_start_x, q_start_y, q_end_x, q_end_y,
		input  ready
	);
	modport sink (
		input  valid, p_start_x, p_start_y, p_end_x, p_end_y,
		input  q_start_x, q_start_y, q_end_x, q_end_y,
		output ready
	);
endinterface

interface soc_out_if;
	logic valid;
	logic ready;
	logic occludes;
	logic may_occlude;
	logic occludes_near_crossing;
	logic sorts_first;
	logic degenerate;

	modport source (
		output valid, occludes, may_occlude, occludes_near_crossing, sorts_first, degenerate,
		input  ready
	);
	modport sink (
		input  valid, occludes, may_occlude, occludes_near_crossing, sorts_first, degenerate,
		output ready
	);
endinterface
`default_nettype wire

// ===== hdl/soc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soc_div: pipelined unsigned restoring divider
// One quotient bit per stage.
// ----------------------------------------------------------------------------
module soc_div #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] n,
	input  wire logic [DW-1:0] d,
	output logic      [NW-1:0] q
);

	logic [NW-1:0] num_q [NW];
	logic [NW-1:0] quo_q [NW];
	logic [DW-1:0] rem_q [NW];
	logic [DW-1:0] den_q [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0] num_i;
		logic [NW-1:0] quo_i;
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign num_i = n;
			assign quo_i = '0;
			assign rem_i = '0;
			assign den_i = d;
		end else begin : g_next
			assign num_i = num_q[k-1];
			assign quo_i = quo_q[k-1];
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
		end

		assign trial = {rem_i, num_i[NW-1]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= {num_i[NW-2:0], 1'b0};
				quo_q[k] <= {quo_i[NW-2:0], ge};
				rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_q[k] <= den_i;
			end
		end
	end

	assign q = quo_q[NW-1];

endmodule
`default_nettype wire

// ===== hdl/soc_orient.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soc_orient: exact sign of a*b - c*d
// Products registered, then difference sign registered.
// ----------------------------------------------------------------------------
module soc_orient #(
	parameter int AW = 26
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [AW-1:0] b,
	input  wire logic signed [AW-1:0] c,
	input  wire logic signed [AW-1:0] d,
	output soc_pkg::sgn_t             sgn
);

	logic signed [2*AW-1:0] prod_l_s3;
	logic signed [2*AW-1:0] prod_r_s3;
	logic signed [2*AW:0]   dif;
	soc_pkg::sgn_t          sgn_s4;

	assign dif = (2*AW+1)'(prod_l_s3) - (2*AW+1)'(prod_r_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s3  <= a * b;
			prod_r_s3  <= c * d;
			sgn_s4.neg <= dif[2*AW];
			sgn_s4.pos <= !dif[2*AW] && (dif != '0);
		end
	end

	assign sgn = sgn_s4;

endmodule
`default_nettype wire

// ===== hdl/segment_occlusion_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_occlusion_test: depth-order occlusion test of two 2D segments
// Tests whether segment P occludes segment Q seen from the origin.
// ----------------------------------------------------------------------------
// Usage:
//   in_pair carries one segment pair (P, Q) per transfer; result carries the
//   five flags for that pair, in order, one result transfer per input.
//   The pipeline depth is set by the bit-per-stage projection dividers. One pair
//   is taken every cycle while the output stage is empty or being taken.
//   Reset clears every stage valid bit; the pipeline comes up empty.
//   When result is stalled the whole pipeline holds and in_pair.ready drops;
//   ready is high whenever the output stage is empty or being taken.
// ----------------------------------------------------------------------------
module segment_occlusion_test #(
	parameter int COORD_WIDTH = 24,
	parameter int QUOT_FRAC   = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	soc_in_if.sink   in_pair,
	soc_out_if.source result
);

	localparam int CW  = COORD_WIDTH;
	localparam int AW  = CW + 2;
	localparam int NW  = CW + QUOT_FRAC;
	localparam int QW  = NW + 2;
	localparam int LAT = NW + 5;
	localparam logic signed [QW-1:0] QSAT = QW'(1) << NW;

	localparam int P0X = 0, P0Y = 1, P1X = 2, P1Y = 3;
	localparam int Q0X = 4, Q0Y = 5, Q1X = 6, Q1Y = 7;

	typedef struct packed {
		logic degen;
		logic both_org;
		logic any_org;
		logic above;
		logic may;
		logic sorts;
		logic dqx_neg;
	} misc_t;

	typedef struct packed {
		logic degen;
		logic both_org;
		logic any_org;
		logic orient_ok;
		logic may;
		logic sorts;
		logic near;
	} fin_t;

	typedef struct packed {
		logic yzero;
		logic xpos;
		logic neg;
	} pt_t;

	logic                 en;
	logic [LAT-1:0]       vld_q;
	logic signed [CW-1:0] c_s1 [8];

	// stage 2
	logic signed [AW-1:0] ori_s2 [7][4];
	logic signed [AW-1:0] ori_d  [7][4];
	misc_t                misc_d, misc_s2, misc_s3, misc_s4;
	logic [NW-1:0]        num_d [4];
	logic [CW-1:0]        den_d [4];
	logic [NW-1:0]        num_s2 [4];
	logic [CW-1:0]        den_s2 [4];
	pt_t                  pt_d [4];
	pt_t                  pt_dq [NW+1][4];

	soc_pkg::sgn_t        os [7];
	fin_t                 fin_d;
	fin_t                 fin_dq [NW];
	logic                 q_fail, p_fail;

	logic [NW-1:0]        qmag [4];
	logic signed [QW-1:0] quo_s [4];
	logic signed [QW-1:0] amin_s, amax_s, bmin_s, bmax_s;
	logic                 proj_ok;

	logic out_occ_q, out_may_q, out_near_q, out_sorts_q, out_degen_q;

	assign en            = !vld_q[LAT-1] || result.ready;
	assign in_pair.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_pair.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1[P0X] <= in_pair.p_start_x;
			c_s1[P0Y] <= in_pair.p_start_y;
			c_s1[P1X] <= in_pair.p_end_x;
			c_s1[P1Y] <= in_pair.p_end_y;
			c_s1[Q0X] <= in_pair.q_start_x;
			c_s1[Q0Y] <= in_pair.q_start_y;
			c_s1[Q1X] <= in_pair.q_end_x;
			c_s1[Q1Y] <= in_pair.q_end_y;
		end
	end

	// orientation operands: (bx-ax)(cy-ay) - (by-ay)(cx-ax)
	always_comb begin
		logic p0o, p1o, q0o, q1o;
		logic signed [CW-1:0] pmax, pmin, qmin;
		// Q line against P0, P1, origin
		ori_d[0][0] = AW'(c_s1[Q1X]) - AW'(c_s1[Q0X]);
		ori_d[0][1] = AW'(c_s1[P0Y]) - AW'(c_s1[Q0Y]);
		ori_d[0][2] = AW'(c_s1[Q1Y]) - AW'(c_s1[Q0Y]);
		ori_d[0][3] = AW'(c_s1[P0X]) - AW'(c_s1[Q0X]);
		ori_d[1][0] = ori_d[0][0];
		ori_d[1][1] = AW'(c_s1[P1Y]) - AW'(c_s1[Q0Y]);
		ori_d[1][2] = ori_d[0][2];
		ori_d[1][3] = AW'(c_s1[P1X]) - AW'(c_s1[Q0X]);
		ori_d[2][0] = ori_d[0][0];
		ori_d[2][1] = -AW'(c_s1[Q0Y]);
		ori_d[2][2] = ori_d[0][2];
		ori_d[2][3] = -AW'(c_s1[Q0X]);
		// P line against Q0, Q1, origin
		ori_d[3][0] = AW'(c_s1[P1X]) - AW'(c_s1[P0X]);
		ori_d[3][1] = AW'(c_s1[Q0Y]) - AW'(c_s1[P0Y]);
		ori_d[3][2] = AW'(c_s1[P1Y]) - AW'(c_s1[P0Y]);
		ori_d[3][3] = AW'(c_s1[Q0X]) - AW'(c_s1[P0X]);
		ori_d[4][0] = ori_d[3][0];
		ori_d[4][1] = AW'(c_s1[Q1Y]) - AW'(c_s1[P0Y]);
		ori_d[4][2] = ori_d[3][2];
		ori_d[4][3] = AW'(c_s1[Q1X]) - AW'(c_s1[P0X]);
		ori_d[5][0] = ori_d[3][0];
		ori_d[5][1] = -AW'(c_s1[P0Y]);
		ori_d[5][2] = ori_d[3][2];
		ori_d[5][3] = -AW'(c_s1[P0X]);
		// doubled midpoint offset dotted with Q normal
		ori_d[6][0] = AW'(c_s1[P0X]) + AW'(c_s1[P1X]) - (AW'(c_s1[Q0X]) <<< 1);
		ori_d[6][1] = ori_d[0][2];
		ori_d[6][2] = AW'(c_s1[P0Y]) + AW'(c_s1[P1Y]) - (AW'(c_s1[Q0Y]) <<< 1);
		ori_d[6][3] = ori_d[0][0];

		p0o  = (c_s1[P0X] == '0) && (c_s1[P0Y] == '0);
		p1o  = (c_s1[P1X] == '0) && (c_s1[P1Y] == '0);
		q0o  = (c_s1[Q0X] == '0) && (c_s1[Q0Y] == '0);
		q1o  = (c_s1[Q1X] == '0) && (c_s1[Q1Y] == '0);
		pmax = (c_s1[P0Y] > c_s1[P1Y]) ? c_s1[P0Y] : c_s1[P1Y];
		pmin = (c_s1[P0Y] < c_s1[P1Y]) ? c_s1[P0Y] : c_s1[P1Y];
		qmin = (c_s1[Q0Y] < c_s1[Q1Y]) ? c_s1[Q0Y] : c_s1[Q1Y];

		misc_d.degen    = ((c_s1[P0X] == c_s1[P1X]) && (c_s1[P0Y] == c_s1[P1Y])) ||
		                  ((c_s1[Q0X] == c_s1[Q1X]) && (c_s1[Q0Y] == c_s1[Q1Y]));
		misc_d.both_org = (p0o || p1o) && (q0o || q1o);
		misc_d.any_org  = p0o || p1o || q0o || q1o;
		misc_d.above    = !c_s1[P0Y][CW-1] && !c_s1[P1Y][CW-1] &&
		                  !c_s1[Q0Y][CW-1] && !c_s1[Q1Y][CW-1];
		misc_d.may      = pmax > qmin;
		misc_d.sorts    = pmin < qmin;
		misc_d.dqx_neg  = ori_d[0][0][AW-1];
	end

	// divider operands per endpoint
	for (genvar i = 0; i < 4; i++) begin : g_pt
		logic signed [CW-1:0] x, y;
		logic [CW-1:0]        xabs;
		assign x    = c_s1[2*i];
		assign y    = c_s1[2*i+1];
		assign xabs = x[CW-1] ? (~x + 1'b1) : x;
		assign num_d[i] = {xabs, {QUOT_FRAC{1'b0}}};
		assign den_d[i] = y[CW-1] ? (~y + 1'b1) : y;
		assign pt_d[i].yzero = (y == '0);
		assign pt_d[i].xpos  = !x[CW-1] && (x != '0);
		assign pt_d[i].neg   = x[CW-1] ^ y[CW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ori_s2  <= ori_d;
			misc_s2 <= misc_d;
			misc_s3 <= misc_s2;
			misc_s4 <= misc_s3;
			num_s2  <= num_d;
			den_s2  <= den_d;
			pt_dq[0] <= pt_d;
			for (int k = 1; k <= NW; k++) begin
				pt_dq[k] <= pt_dq[k-1];
			end
		end
	end

	for (genvar j = 0; j < 7; j++) begin : g_ori
		soc_orient #(.AW(AW)) u_orient (
			.clk (clk),
			.en  (en),
			.a   (ori_s2[j][0]),
			.b   (ori_s2[j][1]),
			.c   (ori_s2[j][2]),
			.d   (ori_s2[j][3]),
			.sgn (os[j])
		);
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		soc_div #(.NW(NW), .DW(CW)) u_div (
			.clk (clk),
			.en  (en),
			.n   (num_s2[i]),
			.d   (den_s2[i]),
			.q   (qmag[i])
		);
	end

	// half-space decision
	always_comb begin
		if (os[2].pos != misc_s4.above) begin
			q_fail = !os[0].pos && !os[1].pos;
		end else begin
			q_fail = !os[0].neg && !os[1].neg;
		end
		if (os[5].pos != misc_s4.above) begin
			p_fail = !os[3].neg && !os[4].neg;
		end else begin
			p_fail = !os[3].pos && !os[4].pos;
		end
		fin_d.degen     = misc_s4.degen;
		fin_d.both_org  = misc_s4.both_org;
		fin_d.any_org   = misc_s4.any_org;
		fin_d.orient_ok = !q_fail && !p_fail;
		fin_d.may       = misc_s4.may;
		fin_d.sorts     = misc_s4.sorts;
		fin_d.near      = misc_s4.dqx_neg ? os[6].pos : os[6].neg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_dq[0] <= fin_d;
			for (int k = 1; k < NW; k++) begin
				fin_dq[k] <= fin_dq[k-1];
			end
		end
	end

	// signed projections, saturated on zero y
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				if (pt_dq[NW][i].yzero) begin
					quo_s[i] <= pt_dq[NW][i].xpos ? QSAT : -QSAT;
				end else if (pt_dq[NW][i].neg) begin
					quo_s[i] <= -$signed({2'b00, qmag[i]});
				end else begin
					quo_s[i] <= $signed({2'b00, qmag[i]});
				end
			end
			amin_s <= (quo_s[0] < quo_s[1]) ? quo_s[0] : quo_s[1];
			amax_s <= (quo_s[0] > quo_s[1]) ? quo_s[0] : quo_s[1];
			bmin_s <= (quo_s[2] < quo_s[3]) ? quo_s[2] : quo_s[3];
			bmax_s <= (quo_s[2] > quo_s[3]) ? quo_s[2] : quo_s[3];
		end
	end

	assign proj_ok = fin_dq[NW-1].any_org ||
	                 (!(amin_s >= bmax_s) && !(bmin_s >= amax_s));

	always_ff @(posedge clk) begin
		if (en) begin
			out_occ_q   <= !fin_dq[NW-1].degen && !fin_dq[NW-1].both_org &&
			               proj_ok && fin_dq[NW-1].orient_ok;
			out_may_q   <= fin_dq[NW-1].may;
			out_near_q  <= fin_dq[NW-1].near;
			out_sorts_q <= fin_dq[NW-1].sorts;
			out_degen_q <= fin_dq[NW-1].degen;
		end
	end

	assign result.valid                  = vld_q[LAT-1];
	assign result.occludes               = out_occ_q;
	assign result.may_occlude            = out_may_q;
	assign result.occludes_near_crossing = out_near_q;
	assign result.sorts_first            = out_sorts_q;
	assign result.degenerate             = out_degen_q;

endmodule
`default_nettype wire

// ===== hdl/soc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soc_checker: port-level checks of the segment occlusion test
// Bound to the top level; sees its channel signals only.
// ----------------------------------------------------------------------------
module soc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic occludes,
	input wire logic may_occlude,
	input wire logic occludes_near_crossing,
	input wire logic sorts_first,
	input wire logic degenerate
);

	a_ready_follows_out : assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not track output stage");

	a_degen_no_occ : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> !occludes)
		else $error("degenerate pair flagged as occluding");

	a_valid_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_flags_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(occludes) && $stable(may_occlude) &&
			$stable(occludes_near_crossing) && $stable(sorts_first) &&
			$stable(degenerate))
		else $error("result changed while stalled");

endmodule

bind segment_occlusion_test soc_checker u_soc_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.in_ready               (in_pair.ready),
	.out_valid              (result.valid),
	.out_ready              (result.ready),
	.occludes               (result.occludes),
	.may_occlude            (result.may_occlude),
	.occludes_near_crossing (result.occludes_near_crossing),
	.sorts_first            (result.sorts_first),
	.degenerate             (result.degenerate)
);
`default_nettype wire

// ===== tb/sv/tb_segment_occlusion_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_occlusion_test: self-checking bench for the segment occlusion test
// Drives directed and random segment pairs with random gaps and output stalls,
// predicts the five flags per pair and compares every result transfer in order.
// ----------------------------------------------------------------------------
module tb_segment_occlusion_test;

	localparam int CW = 24;
	localparam int QF = 16;
	localparam int LATENCY = CW + QF + 5;
	localparam int WATCHDOG = 5000;
	localparam longint QSAT = 64'sd1 << 62;

	typedef struct {
		logic occ, may, near, first, degen;
	} flags_t;

	typedef logic signed [CW-1:0] pair_t [8];

	class flag_board;
		flags_t pending[$];
		int errors;

		function longint proj(longint x, longint y);
			if (y == 0) return x > 0 ? QSAT : -QSAT;
			return (x * (64'sd1 <<< QF)) / y;
		endfunction

		function int orient(longint ax, longint ay, longint bx, longint by,
				longint cx, longint cy);
			logic signed [127:0] v;
			v = 128'(bx - ax) * 128'(cy - ay) - 128'(by - ay) * 128'(cx - ax);
			return v > 0 ? 1 : (v < 0 ? -1 : 0);
		endfunction

		function bit occ_test(longint c[8]);
			bit p0o, p1o, q0o, q1o, above;
			int oa, ob, ov;
			longint a0, a1, b0, b1;
			p0o = c[0] == 0 && c[1] == 0; p1o = c[2] == 0 && c[3] == 0;
			q0o = c[4] == 0 && c[5] == 0; q1o = c[6] == 0 && c[7] == 0;
			above = c[1] >= 0 && c[3] >= 0 && c[5] >= 0 && c[7] >= 0;
			if ((p0o || p1o) && (q0o || q1o)) return 0;
			if (!p0o && !p1o && !q0o && !q1o) begin
				a0 = proj(c[0], c[1]); a1 = proj(c[2], c[3]);
				b0 = proj(c[4], c[5]); b1 = proj(c[6], c[7]);
				if ((a0 < a1 ? a0 : a1) >= (b0 > b1 ? b0 : b1)) return 0;
				if ((b0 < b1 ? b0 : b1) >= (a0 > a1 ? a0 : a1)) return 0;
			end
			oa = orient(c[4], c[5], c[6], c[7], c[0], c[1]);
			ob = orient(c[4], c[5], c[6], c[7], c[2], c[3]);
			ov = orient(c[4], c[5], c[6], c[7], 0, 0);
			if ((ov > 0) != above) begin
				if (oa <= 0 && ob <= 0) return 0;
			end else if (oa >= 0 && ob >= 0) return 0;
			oa = orient(c[0], c[1], c[2], c[3], c[4], c[5]);
			ob = orient(c[0], c[1], c[2], c[3], c[6], c[7]);
			ov = orient(c[0], c[1], c[2], c[3], 0, 0);
			if ((ov > 0) != above) begin
				if (oa >= 0 && ob >= 0) return 0;
			end else if (oa <= 0 && ob <= 0) return 0;
			return 1;
		endfunction

		function void note_pair(pair_t pr);
			longint c[8];
			longint nx, ny, mx, my, pmin, pmax, qmin;
			logic signed [127:0] d;
			flags_t f;
			foreach (c[i]) c[i] = pr[i];
			f.degen = (c[0] == c[2] && c[1] == c[3]) || (c[4] == c[6] && c[5] == c[7]);
			f.occ = !f.degen && occ_test(c);
			nx = c[7] - c[5];
			ny = -(c[6] - c[4]);
			mx = c[0] + c[2] - 2 * c[4];
			my = c[1] + c[3] - 2 * c[5];
			d = 128'(mx) * 128'(nx) + 128'(my) * 128'(ny);
			f.near = ny > 0 ? d > 0 : d < 0;
			pmin = c[1] < c[3] ? c[1] : c[3];
			pmax = c[1] > c[3] ? c[1] : c[3];
			qmin = c[5] < c[7] ? c[5] : c[7];
			f.may = pmax > qmin;
			f.first = pmin < qmin;
			pending = {pending, f};
		endfunction

		task report(string msg);
			$display("mismatch %s", msg);
			errors++;
		endtask

		task check_result(flags_t got);
			flags_t w;
			if (pending.size() == 0) begin
				report("result transfer with none pending");
				return;
			end
			w = pending.pop_front();
			if (got.occ !== w.occ)
				report($sformatf("occludes: got %0b expected %0b", got.occ, w.occ));
			if (got.may !== w.may)
				report($sformatf("may_occlude: got %0b expected %0b", got.may, w.may));
			if (got.near !== w.near)
				report($sformatf("occludes_near_crossing: got %0b expected %0b",
					got.near, w.near));
			if (got.first !== w.first)
				report($sformatf("sorts_first: got %0b expected %0b", got.first, w.first));
			if (got.degen !== w.degen)
				report($sformatf("degenerate: got %0b expected %0b", got.degen, w.degen));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	int quiet_cycles = 0;
	flag_board board = new();

	soc_in_if #(.CW(CW)) in_pair ();
	soc_out_if result ();

	segment_occlusion_test #(.COORD_WIDTH(CW), .QUOT_FRAC(QF)) dut (
		.clk(clk), .arst_n(arst_n), .in_pair(in_pair), .result(result)
	);

	always #6 clk = ~clk;

	initial begin
		in_pair.valid = 0;
		{in_pair.p_start_x, in_pair.p_start_y, in_pair.p_end_x, in_pair.p_end_y} = '0;
		{in_pair.q_start_x, in_pair.q_start_y, in_pair.q_end_x, in_pair.q_end_y} = '0;
		result.ready = 0;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// output stall pattern, with stretches of no stall
	int stall_left = 0;
	int free_left = 0;
	always @(posedge clk) begin
		if (result.valid && result.ready)
			board.check_result('{result.occludes, result.may_occlude,
				result.occludes_near_crossing, result.sorts_first, result.degenerate});
		if ((in_pair.valid && in_pair.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (!arst_n) begin
			result.ready <= 0;
		end else if (free_left > 0) begin
			free_left <= free_left - 1;
			result.ready <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result.ready <= 0;
		end else if ($urandom_range(0, 9) == 0) begin
			free_left <= $urandom_range(50, 200);
			result.ready <= 1;
		end else begin
			stall_left <= gap_len();
			result.ready <= 1;
		end
	end

	task send_pair(pair_t pr);
		int g;
		g = gap_len();
		repeat (g) begin
			in_pair.valid <= 0;
			@(posedge clk);
		end
		in_pair.valid <= 1;
		in_pair.p_start_x <= pr[0]; in_pair.p_start_y <= pr[1];
		in_pair.p_end_x <= pr[2]; in_pair.p_end_y <= pr[3];
		in_pair.q_start_x <= pr[4]; in_pair.q_start_y <= pr[5];
		in_pair.q_end_x <= pr[6]; in_pair.q_end_y <= pr[7];
		do @(posedge clk); while (!in_pair.ready);
		board.note_pair(pr);
	endtask

	function logic signed [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return CW'($urandom);
			1: return CW'($signed($urandom_range(0, 64)) - 32);
			2: return CW'($signed($urandom_range(0, 8000)) - 4000);
			default: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
		endcase
	endfunction

	task run_directed();
		pair_t pr;
		logic signed [CW-1:0] mx, mn;
		mx = 24'sh7fffff; mn = 24'sh800000;
		pr = '{mx, mx, mn, mn, mn, mx, mx, mn}; send_pair(pr);
		pr = '{mn, mn, mn, mn, 1, 1, 2, 3}; send_pair(pr);
		pr = '{1, 2, 3, 4, 5, 5, 5, 5}; send_pair(pr);
		pr = '{0, 0, 4, 4, 0, 0, -4, 4}; send_pair(pr);
		pr = '{0, 0, 4, 4, 2, 8, -4, 4}; send_pair(pr);
		pr = '{2, 8, 4, 4, 0, 0, -4, 4}; send_pair(pr);
		pr = '{-4, 0, 4, 0, -8, 5, 8, 5}; send_pair(pr);
		pr = '{-4, 5, 4, 5, -8, 0, 8, 0}; send_pair(pr);
		pr = '{-4, 2, 4, 2, -8, 9, 8, 9}; send_pair(pr);
		pr = '{-4, -2, 4, -2, -8, -9, 8, -9}; send_pair(pr);
		pr = '{-4, 3, 4, -3, -8, 9, 8, 9}; send_pair(pr);
		pr = '{1, 4, 1, 4, 1, 4, 1, 4}; send_pair(pr);
		pr = '{3, 0, 5, 0, 7, 2, 9, 2}; send_pair(pr);
		pr = '{-3, 0, -5, 0, 7, 0, -9, 0}; send_pair(pr);
		pr = '{mx, 1, mn, -1, mx, mx, mn, mx}; send_pair(pr);
		pr = '{1, 10, 5, 10, 2, 20, 6, 20}; send_pair(pr);
		pr = '{-1, -1, 1, 1, 1, -1, -1, 1}; send_pair(pr);
		pr = '{10, 20, 30, 40, 10, 20, 30, 40}; send_pair(pr);
	endtask

	task run_random(int count);
		pair_t pr;
		int mode, k;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 9);
			foreach (pr[i])
				pr[i] = rand_coord(mode < 3 ? 0 : (mode < 6 ? 1 : (mode < 9 ? 2 : 3)));
			k = $urandom_range(0, 15);
			if (k == 0) begin
				pr[2] = pr[0]; pr[3] = pr[1];
			end else if (k == 1) begin
				pr[6] = pr[4]; pr[7] = pr[5];
			end else if (k == 2) begin
				pr[2 * $urandom_range(0, 1)] = 0;
				pr[2 * $urandom_range(0, 1) + 1] = 0;
				{pr[0], pr[1]} = '0;
			end else if (k == 3) begin
				{pr[4], pr[5]} = '0;
			end else if (k == 4) begin
				pr[$urandom_range(0, 3) * 2 + 1] = 0;
			end else if (k == 5) begin
				{pr[0], pr[1]} = '0; {pr[6], pr[7]} = '0;
			end
			send_pair(pr);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_directed();
		run_random(500);
		in_pair.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		run_random(600);
		in_pair.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG);
		$display("simulation failed");
		$finish;
	end

endmodule
